FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clock while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising edge of clock, reset included.
`define ASSERT_CLK_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: sv/cpsp_pkg.sv
`timescale 1ns / 1ps

package cpsp_pkg;

   localparam int NUM_MOTORS = 2;
   localparam int DELTA_W    = 17;
   localparam int POS_W      = 32;
   localparam int ERR_W      = 33;
   localparam int DIFF_W     = 34;
   localparam int INTEG_W    = 17;
   localparam int SERR_W     = 17;
   localparam int D1_W       = 18;
   localparam int D2_W       = 19;
   localparam int OPND_W     = 34;
   localparam int MAG_W      = 33;
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = MAG_W + GAIN_W;
   localparam int SUM_W      = PROD_W + 3;
   localparam int ACC_W      = 40;
   localparam int DRIVE_W    = 13;
   localparam int VLIM_W     = 15;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_GAINS  = 6;
   localparam int GAIN_IDX_W = 3;

   typedef struct packed {
      logic                     valid;
      logic                     first;
      logic [GAIN_W-1:0]        gain;
      logic signed [OPND_W-1:0] operand;
   } mul_req_type;

endpackage

FILE: sv/cpsp_mulq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpsp_mulq import cpsp_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mul_req_type             mul_req,
   output logic signed [SUM_W-1:0] mul_sum
);

   logic                    s1_valid_ff, s1_first_ff, s1_neg_ff;
   logic [MAG_W-1:0]        s1_mag_ff;
   logic [GAIN_W-1:0]       s1_gain_ff;
   logic                    s2_valid_ff, s2_first_ff, s2_neg_ff;
   logic [PROD_W-1:0]       s2_prod_ff;
   logic signed [SUM_W-1:0] acc_ff;

   logic [MAG_W-1:0]        mag_in;
   logic [PROD_W-1:0]       prod_in;
   logic signed [SUM_W-1:0] term;
   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] acc_in;

   always_comb begin
      if (mul_req.operand[OPND_W-1]) begin
         mag_in = MAG_W'(-mul_req.operand);
      end else begin
         mag_in = MAG_W'(mul_req.operand);
      end
      prod_in = s1_mag_ff * s1_gain_ff;
      term    = SUM_W'(s2_prod_ff >> FRAC_BITS);
      base    = s2_first_ff ? '0 : acc_ff;
      acc_in  = s2_neg_ff ? base - term : base + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= mul_req.valid;
         s2_valid_ff <= s1_valid_ff;
         if (mul_req.valid) begin
            s1_first_ff <= mul_req.first;
            s1_neg_ff   <= mul_req.operand[OPND_W-1];
            s1_mag_ff   <= mag_in;
            s1_gain_ff  <= mul_req.gain;
         end
         if (s1_valid_ff) begin
            s2_first_ff <= s1_first_ff;
            s2_neg_ff   <= s1_neg_ff;
            s2_prod_ff  <= prod_in;
         end
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign mul_sum = acc_ff;

   `ASSERT_CLK(a_sum_holds_when_idle, !s2_valid_ff |=> $stable(acc_ff), "sum changed without a product")
   `ASSERT_CLK(a_first_zero_clears, (s2_valid_ff && s2_first_ff && s2_prod_ff == '0) |=> (acc_ff == '0), "first zero product did not clear the sum")

endmodule

FILE: sv/cascaded_position_speed_pid.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Two-motor cascaded controller: each accepted word carries one encoder delta per motor
// (the right one is negated), updates that motor's position, runs a clamped positional
// PID to a speed command and an incremental speed PID into a saturating accumulator, and
// returns both PWM duties clamped to plus or minus DRIVE_LIMIT. The motors are handled in
// turn through one shared 33 by 16 bit gain multiplier with a three-stage pipeline; each
// motor takes two groups of three products, one for each PID, plus adds and clamps. The
// input is not ready while a word is being worked on; one finished result may wait in
// the output register while the next word is taken. Registers are written on any cycle
// with csr_we high, and should be written only while the block is idle.

module cascaded_position_speed_pid import cpsp_pkg::*; #(
   parameter int DRIVE_LIMIT    = 2500,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [15:0]        req_count_left,
   input  logic signed [15:0]        req_count_right_raw,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DRIVE_W-1:0] rsp_drive_left,
   output logic signed [DRIVE_W-1:0] rsp_drive_right,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET, CSR_VLIMIT, CSR_POS_KP, CSR_POS_KI,
      CSR_POS_KD, CSR_SPD_KP, CSR_SPD_KI, CSR_SPD_KD
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_POS, S_ERR, S_INT, S_PMUL, S_CMD, S_SERR, S_SDIF, S_SMUL,
      S_ACC, S_DRV, S_DONE
   } state_type;

   localparam logic [2:0] TERMS     = 3'd3;
   localparam logic [2:0] STEP_LAST = 3'd4;
   localparam logic [GAIN_IDX_W-1:0] SPD_GAIN_BASE = GAIN_IDX_W'(3);
   localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] DRV_HI = ACC_W'(DRIVE_LIMIT);
   localparam logic signed [ACC_W-1:0] DRV_LO = -DRV_HI;
   localparam int DRIVE_FIELD_MAX = 2 ** (DRIVE_W - 1) - 1;

   state_type                 state_ff;
   logic                      motor_ff;
   logic [2:0]                step_ff;
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] rsp_left_ff, rsp_right_ff;

   logic signed [POS_W-1:0]  target_ff;
   logic [VLIM_W-1:0]        vlimit_ff;
   logic [GAIN_W-1:0]        gain_ff [NUM_GAINS];

   logic signed [POS_W-1:0]   pos_ff   [NUM_MOTORS];
   logic signed [INTEG_W-1:0] integ_ff [NUM_MOTORS];
   logic signed [ERR_W-1:0]   perr_ff  [NUM_MOTORS];
   logic signed [SERR_W-1:0]  sp_ff    [NUM_MOTORS];
   logic signed [SERR_W-1:0]  sp2_ff   [NUM_MOTORS];
   logic signed [ACC_W-1:0]   acc_ff   [NUM_MOTORS];
   logic signed [DRIVE_W-1:0] drive_ff [NUM_MOTORS];
   logic signed [DELTA_W-1:0] delta_ff [NUM_MOTORS];

   logic signed [ERR_W-1:0]   err_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [INTEG_W-1:0] cmd_ff;
   logic signed [SERR_W-1:0]  serr_ff;
   logic signed [D1_W-1:0]    d1_ff;
   logic signed [D2_W-1:0]    d2_ff;

   logic signed [DELTA_W-1:0] delta;
   logic signed [INTEG_W-1:0] vlim_pos, vlim_neg;
   logic signed [POS_W-1:0]   pos_in;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [DIFF_W-1:0]  isum;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [DIFF_W-1:0]  diff_in;
   logic signed [INTEG_W-1:0] cmd_in;
   logic signed [SERR_W-1:0]  serr_in;
   logic signed [D1_W-1:0]    d1_in;
   logic signed [D2_W-1:0]    d2_in;
   logic signed [SUM_W:0]     acc_sum;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   drive_full;
   logic [GAIN_IDX_W-1:0]     gsel;
   logic [GAIN_IDX_W-1:0]     csr_gidx;
   mul_req_type               mul_req;
   logic signed [SUM_W-1:0]   mul_sum;

   cpsp_mulq #(
      .FRAC_BITS (GAIN_FRAC_BITS)
   ) u_mulq (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_sum (mul_sum)
   );

   always_comb begin
      delta    = delta_ff[motor_ff];
      vlim_pos = signed'({2'b00, vlimit_ff});
      vlim_neg = -vlim_pos;
      pos_in   = pos_ff[motor_ff] + POS_W'(delta);
      err_in   = ERR_W'(target_ff) - ERR_W'(pos_ff[motor_ff]);
      isum     = DIFF_W'(integ_ff[motor_ff]) + DIFF_W'(err_ff);
      if (isum > DIFF_W'(vlim_pos)) begin
         integ_in = vlim_pos;
      end else if (isum < DIFF_W'(vlim_neg)) begin
         integ_in = vlim_neg;
      end else begin
         integ_in = isum[INTEG_W-1:0];
      end
      diff_in = DIFF_W'(err_ff) - DIFF_W'(perr_ff[motor_ff]);
      if (mul_sum > SUM_W'(vlim_pos)) begin
         cmd_in = vlim_pos;
      end else if (mul_sum < SUM_W'(vlim_neg)) begin
         cmd_in = vlim_neg;
      end else begin
         cmd_in = mul_sum[INTEG_W-1:0];
      end
      serr_in = SERR_W'(D1_W'(cmd_ff) - D1_W'(delta));
      d1_in   = D1_W'(serr_ff) - D1_W'(sp_ff[motor_ff]);
      d2_in   = D2_W'(serr_ff) - D2_W'(sp_ff[motor_ff]) - D2_W'(sp_ff[motor_ff])
              + D2_W'(sp2_ff[motor_ff]);
      acc_sum = (SUM_W+1)'(acc_ff[motor_ff]) + (SUM_W+1)'(mul_sum);
      if (acc_sum > (SUM_W+1)'(ACC_HI)) begin
         acc_in = ACC_HI;
      end else if (acc_sum < (SUM_W+1)'(ACC_LO)) begin
         acc_in = ACC_LO;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end
      if (acc_ff[motor_ff] > DRV_HI) begin
         drive_full = DRV_HI;
      end else if (acc_ff[motor_ff] < DRV_LO) begin
         drive_full = DRV_LO;
      end else begin
         drive_full = acc_ff[motor_ff];
      end
      csr_gidx = GAIN_IDX_W'(csr_index - CSR_POS_KP);
   end

   always_comb begin
      mul_req.valid   = 1'b0;
      mul_req.first   = (step_ff == 3'd0);
      mul_req.operand = '0;
      gsel            = '0;
      if ((state_ff == S_PMUL || state_ff == S_SMUL) && step_ff < TERMS) begin
         mul_req.valid = 1'b1;
         gsel          = GAIN_IDX_W'(step_ff);
         if (state_ff == S_SMUL) begin
            gsel = GAIN_IDX_W'(step_ff) + SPD_GAIN_BASE;
         end
         case (step_ff)
            3'd0: begin
               mul_req.operand = (state_ff == S_PMUL) ? OPND_W'(err_ff) : OPND_W'(d1_ff);
            end
            3'd1: begin
               mul_req.operand = (state_ff == S_PMUL) ? OPND_W'(integ_ff[motor_ff])
                                                      : OPND_W'(serr_ff);
            end
            default: begin
               mul_req.operand = (state_ff == S_PMUL) ? OPND_W'(diff_ff) : OPND_W'(d2_ff);
            end
         endcase
      end
      mul_req.gain = gain_ff[gsel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         motor_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         vlimit_ff    <= '0;
         for (int g = 0; g < NUM_GAINS; g++) begin
            gain_ff[g] <= '0;
         end
         for (int m = 0; m < NUM_MOTORS; m++) begin
            pos_ff[m]   <= '0;
            integ_ff[m] <= '0;
            perr_ff[m]  <= '0;
            sp_ff[m]    <= '0;
            sp2_ff[m]   <= '0;
            acc_ff[m]   <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET: target_ff <= signed'(csr_wdata);
               CSR_VLIMIT: vlimit_ff <= csr_wdata[VLIM_W-1:0];
               CSR_POS_KP, CSR_POS_KI, CSR_POS_KD, CSR_SPD_KP, CSR_SPD_KI, CSR_SPD_KD: begin
                  gain_ff[csr_gidx] <= csr_wdata[GAIN_W-1:0];
               end
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  delta_ff[0] <= DELTA_W'(req_count_left);
                  delta_ff[1] <= -DELTA_W'(req_count_right_raw);
                  motor_ff    <= 1'b0;
                  state_ff    <= S_POS;
               end
            end
            S_POS: begin
               pos_ff[motor_ff] <= pos_in;
               state_ff         <= S_ERR;
            end
            S_ERR: begin
               err_ff   <= err_in;
               state_ff <= S_INT;
            end
            S_INT: begin
               integ_ff[motor_ff] <= integ_in;
               diff_ff            <= diff_in;
               perr_ff[motor_ff]  <= err_ff;
               step_ff            <= '0;
               state_ff           <= S_PMUL;
            end
            S_PMUL: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_LAST) begin
                  state_ff <= S_CMD;
               end
            end
            S_CMD: begin
               cmd_ff   <= cmd_in;
               state_ff <= S_SERR;
            end
            S_SERR: begin
               serr_ff  <= serr_in;
               state_ff <= S_SDIF;
            end
            S_SDIF: begin
               d1_ff            <= d1_in;
               d2_ff            <= d2_in;
               sp2_ff[motor_ff] <= sp_ff[motor_ff];
               sp_ff[motor_ff]  <= serr_ff;
               step_ff          <= '0;
               state_ff         <= S_SMUL;
            end
            S_SMUL: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_LAST) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               acc_ff[motor_ff] <= acc_in;
               state_ff         <= S_DRV;
            end
            S_DRV: begin
               drive_ff[motor_ff] <= drive_full[DRIVE_W-1:0];
               if (motor_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  motor_ff <= 1'b1;
                  state_ff <= S_POS;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff  <= drive_ff[0];
                  rsp_right_ff <= drive_ff[1];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_left  = rsp_left_ff;
   assign rsp_drive_right = rsp_right_ff;

   `ASSERT_CLK_NR(a_reset_to_idle, reset |=> (state_ff == S_IDLE), "reset did not return to idle")
   `ASSERT_CLK(a_accept_starts_left, (req_valid && req_ready) |=> (state_ff == S_POS && motor_ff == 1'b0), "accepted word did not start on the left motor")
   `ASSERT_CLK(a_done_after_right, (state_ff == S_DONE) |-> (motor_ff == 1'b1), "result offered before the right motor was done")
   `ASSERT_CLK(a_drive_in_range, rsp_valid |-> ((DRIVE_LIMIT > DRIVE_FIELD_MAX) || (rsp_drive_left <= DRIVE_LIMIT && rsp_drive_left >= -DRIVE_LIMIT && rsp_drive_right <= DRIVE_LIMIT && rsp_drive_right >= -DRIVE_LIMIT)), "drive outside its limit")

endmodule

FILE: verif/cpsp_checker.sv
`timescale 1ns / 1ps

package cpsp_tb_pkg;

   typedef enum logic [2:0] {
      REG_TARGET_POSITION = 3'd0,
      REG_VELOCITY_LIMIT  = 3'd1,
      REG_POS_GAIN_P      = 3'd2,
      REG_POS_GAIN_I      = 3'd3,
      REG_POS_GAIN_D      = 3'd4,
      REG_SPD_GAIN_P      = 3'd5,
      REG_SPD_GAIN_I      = 3'd6,
      REG_SPD_GAIN_D      = 3'd7
   } csr_reg_type;

endpackage

module cpsp_checker import cpsp_pkg::*, cpsp_tb_pkg::*; #(
   parameter int DRIVE_LIMIT    = 2500,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [15:0]        req_count_left,
   input  logic signed [15:0]        req_count_right_raw,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [DRIVE_W-1:0] rsp_drive_left,
   input  logic signed [DRIVE_W-1:0] rsp_drive_right,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   output int                        fail_count,
   output int                        pending_duties,
   output int                        checked_duties
);

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left;
      logic signed [DRIVE_W-1:0] right;
   } duty_pair_type;

   localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   logic signed [POS_W-1:0]   target_pos;
   logic [VLIM_W-1:0]         vel_limit;
   logic [GAIN_W-1:0]         pos_kp, pos_ki, pos_kd;
   logic [GAIN_W-1:0]         spd_kp, spd_ki, spd_kd;

   logic signed [POS_W-1:0]   position      [NUM_MOTORS];
   logic signed [INTEG_W-1:0] pos_integral  [NUM_MOTORS];
   logic signed [ERR_W-1:0]   pos_last_err  [NUM_MOTORS];
   logic signed [SERR_W-1:0]  spd_last_err  [NUM_MOTORS];
   logic signed [SERR_W-1:0]  spd_older_err [NUM_MOTORS];
   logic signed [ACC_W-1:0]   spd_acc       [NUM_MOTORS];

   duty_pair_type expected_duties [$];

   function automatic longint clamp(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // Gain products are truncated towards zero, each one on its own.
   function automatic longint scale_by_gain(logic [GAIN_W-1:0] g, longint x);
      longint mag;
      longint prod;
      mag = (x < 0) ? -x : x;
      prod = (mag * longint'(g)) >>> GAIN_FRAC_BITS;
      return (x < 0) ? -prod : prod;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] motor_duty(int m, longint delta);
      longint vlim, err, integ, cmd, serr, inc, acc;
      vlim = longint'(vel_limit);
      position[m] = position[m] + POS_W'(delta);
      err = longint'(target_pos) - longint'(position[m]);
      integ = clamp(longint'(pos_integral[m]) + err, -vlim, vlim);
      pos_integral[m] = INTEG_W'(integ);
      cmd = scale_by_gain(pos_kp, err) + scale_by_gain(pos_ki, integ)
          + scale_by_gain(pos_kd, err - longint'(pos_last_err[m]));
      pos_last_err[m] = ERR_W'(err);
      cmd = clamp(cmd, -vlim, vlim);
      serr = cmd - delta;
      inc = scale_by_gain(spd_kp, serr - longint'(spd_last_err[m]))
          + scale_by_gain(spd_ki, serr)
          + scale_by_gain(spd_kd, serr - 2 * longint'(spd_last_err[m])
                                  + longint'(spd_older_err[m]));
      spd_older_err[m] = spd_last_err[m];
      spd_last_err[m] = SERR_W'(serr);
      acc = clamp(longint'(spd_acc[m]) + inc, ACC_MIN, ACC_MAX);
      spd_acc[m] = ACC_W'(acc);
      return DRIVE_W'(clamp(acc, -DRIVE_LIMIT, DRIVE_LIMIT));
   endfunction

   function automatic duty_pair_type predict_duties(logic signed [15:0] left_delta,
                                                    logic signed [15:0] right_raw);
      duty_pair_type d;
      d.left = motor_duty(0, longint'(left_delta));
      d.right = motor_duty(1, -longint'(right_raw));
      return d;
   endfunction

   task automatic report_error(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   always @(posedge clock) begin
      duty_pair_type want;
      if (reset) begin
         target_pos = '0;
         vel_limit = '0;
         pos_kp = '0;
         pos_ki = '0;
         pos_kd = '0;
         spd_kp = '0;
         spd_ki = '0;
         spd_kd = '0;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            position[m] = '0;
            pos_integral[m] = '0;
            pos_last_err[m] = '0;
            spd_last_err[m] = '0;
            spd_older_err[m] = '0;
            spd_acc[m] = '0;
         end
         expected_duties.delete();
      end else begin
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_TARGET_POSITION: target_pos = csr_wdata[POS_W-1:0];
               REG_VELOCITY_LIMIT:  vel_limit = csr_wdata[VLIM_W-1:0];
               REG_POS_GAIN_P:      pos_kp = csr_wdata[GAIN_W-1:0];
               REG_POS_GAIN_I:      pos_ki = csr_wdata[GAIN_W-1:0];
               REG_POS_GAIN_D:      pos_kd = csr_wdata[GAIN_W-1:0];
               REG_SPD_GAIN_P:      spd_kp = csr_wdata[GAIN_W-1:0];
               REG_SPD_GAIN_I:      spd_ki = csr_wdata[GAIN_W-1:0];
               REG_SPD_GAIN_D:      spd_kd = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            checked_duties++;
            if (expected_duties.size() == 0) begin
               report_error($sformatf("%0t: duty word with none outstanding: left %0d right %0d",
                                      $time, rsp_drive_left, rsp_drive_right));
            end else begin
               want = expected_duties.pop_front();
               if (rsp_drive_left !== want.left || rsp_drive_right !== want.right) begin
                  report_error($sformatf(
                     "%0t: duty mismatch: expected left %0d right %0d, got left %0d right %0d",
                     $time, want.left, want.right, rsp_drive_left, rsp_drive_right));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_duties.push_back(predict_duties(req_count_left, req_count_right_raw));
         end
      end
      pending_duties = expected_duties.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb import cpsp_pkg::*, cpsp_tb_pkg::*;;

   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 88;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [15:0]        req_count_left = '0;
   logic signed [15:0]        req_count_right_raw = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive_left;
   logic signed [DRIVE_W-1:0] rsp_drive_right;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int words_sent = 0;
   int settings_used = 0;
   int fail_count;
   int pending_duties;
   int checked_duties;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cascaded_position_speed_pid dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_count_left      (req_count_left),
      .req_count_right_raw (req_count_right_raw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_left      (rsp_drive_left),
      .rsp_drive_right     (rsp_drive_right),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   cpsp_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_count_left      (req_count_left),
      .req_count_right_raw (req_count_right_raw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_left      (rsp_drive_left),
      .rsp_drive_right     (rsp_drive_right),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .pending_duties      (pending_duties),
      .checked_duties      (checked_duties)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Unused upper bits of the write data are filled at random; the block must ignore them.
   task automatic load_settings(input logic signed [POS_W-1:0] target,
                                input logic [VLIM_W-1:0] vlim,
                                input logic [NUM_GAINS-1:0][GAIN_W-1:0] gains);
      write_reg(REG_TARGET_POSITION, target);
      write_reg(REG_VELOCITY_LIMIT, {(CSR_W - VLIM_W)'($urandom), vlim});
      for (int k = 0; k < NUM_GAINS; k++) begin
         write_reg(csr_reg_type'(int'(REG_POS_GAIN_P) + k),
                   {(CSR_W - GAIN_W)'($urandom), gains[k]});
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic pick_settings(input int phase);
      logic [NUM_GAINS-1:0][GAIN_W-1:0] gains;
      logic signed [POS_W-1:0]          target;
      logic [VLIM_W-1:0]                vlim;
      case (phase % 4)
         0: begin
            gains = '1;
            vlim = '1;
            target = (phase % 8 == 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
         end
         1: begin
            for (int k = 0; k < NUM_GAINS; k++) gains[k] = GAIN_W'($urandom);
            vlim = VLIM_W'($urandom);
            target = POS_W'($urandom);
         end
         2: begin
            for (int k = 0; k < NUM_GAINS; k++) gains[k] = GAIN_W'($urandom_range(768));
            vlim = VLIM_W'($urandom_range(4000));
            target = POS_W'(int'($urandom_range(20000)) - 10000);
         end
         default: begin
            for (int k = 0; k < NUM_GAINS; k++) begin
               gains[k] = ($urandom_range(1) == 1) ? 16'h0100 : 16'h0000;
            end
            vlim = VLIM_W'($urandom_range(1));
            target = POS_W'($urandom);
         end
      endcase
      load_settings(target, vlim, gains);
   endtask

   task automatic send_word(input logic signed [15:0] left, input logic signed [15:0] right);
      req_valid <= 1'b1;
      req_count_left <= left;
      req_count_right_raw <= right;
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);
      words_sent++;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(80, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_duties == 0);
      @(posedge clock);
   endtask

   // Mostly small deltas as a running motor gives, with full-range and extreme words mixed in.
   function automatic logic signed [15:0] random_delta();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return 16'(int'($urandom_range(400)) - 200);
      end else if (pick < 85) begin
         return 16'($urandom);
      end
      case ($urandom_range(3))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(16'sh0000, 16'sh0000);
      send_word(16'sh7fff, 16'sh8000);
      send_word(16'sh8000, 16'sh7fff);
      drain();

      load_settings(32'sh7fff_ffff, 15'd0, {NUM_GAINS{16'h0100}});
      send_word(16'sh8000, 16'sh8000);
      send_word(16'sh7fff, 16'sh7fff);
      send_word(16'sh0001, 16'shffff);
      send_word(16'shffff, 16'sh0001);
      drain();

      load_settings(32'sh8000_0000, 15'h7fff, '1);
      repeat (4) send_word(16'sh7fff, 16'sh8000);
      repeat (4) send_word(16'sh8000, 16'sh7fff);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_settings(phase);
         case ((phase + phase / 4) % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 58;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 58;
            end
            default: begin
               send_idle_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         repeat (WORDS_PER_PHASE) send_word(random_delta(), random_delta());
         drain();
      end

      repeat (60) @(posedge clock);
      $display("Sent %0d encoder words under %0d register settings; %0d duty words checked, %0d failures.",
               words_sent, settings_used, checked_duties, fail_count);
      if (fail_count == 0 && pending_duties == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d duty words outstanding.", pending_duties);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
